// File: hw/rtl/deadline_sleep_queue_core_assert.svh
// Assertion macros shared by the sleep queue controller and datapath.
// Each macro expects clk_i and rst_ni to exist in the module that uses it.
`ifndef DEADLINE_SLEEP_QUEUE_CORE_ASSERT_SVH
`define DEADLINE_SLEEP_QUEUE_CORE_ASSERT_SVH

// The condition must never be true while out of reset.
`define DSQ_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define DSQ_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/dsq_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and command/status structs of the sleep queue.
// No dependencies; used by every other source file of the block but the assertion header.
package dsq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PID_BITS    = 15;
  localparam int MAX_RESULTS = 16;

  localparam int KIND_W     = 2;
  localparam int PROC_ID_W  = 15;
  localparam int TIME_W     = 32;
  localparam int STATUS_W   = 3;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int NUM_W = $clog2(MAX_RESULTS + 1);

  typedef logic [PID_BITS-1:0] pid_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [NUM_W-1:0]    num_t;
  typedef logic [TIME_W-1:0]   time_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_TICK   = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_ALREADY   = 3'd1,
    ST_FULL      = 3'd2,
    ST_CANCELLED = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_WOKEN     = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SEARCH,
    OP_INS_START,
    OP_SHIFT_UP,
    OP_INS_WRITE,
    OP_SHIFT_DOWN,
    OP_REMOVE_END,
    OP_POP_HEAD,
    OP_EMIT
  } dp_op_e;

  // Which entry the datapath read port looks at.
  typedef enum logic [1:0] {
    RD_PTR,
    RD_PREV,
    RD_NEXT,
    RD_HEAD
  } rd_sel_e;

  typedef struct packed {
    dp_op_e  op;
    rd_sel_e rd_sel;
    status_e res_status;
    logic    res_last;
  } dsq_cmd_t;

  typedef struct packed {
    logic search_done;
    logic found;
    logic full;
    logic shift_more;
    logic remove_more;
    logic head_due;
    logic room;
    logic pend_valid;
    logic out_free;
  } dsq_stat_t;

endpackage

// File: hw/rtl/dsq_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for sleep queue requests and results.
// Depends on dsq_pkg for the field widths.
interface dsq_req_if ();
  logic                          valid;
  logic                          ready;
  logic [dsq_pkg::KIND_W-1:0]    kind;
  logic [dsq_pkg::PROC_ID_W-1:0] proc_id;
  logic [dsq_pkg::TIME_W-1:0]    time_sec;
  logic [dsq_pkg::TIME_W-1:0]    time_sub;
  logic                          fswait;

  modport source (output valid, kind, proc_id, time_sec, time_sub, fswait, input ready);
  modport sink   (input valid, kind, proc_id, time_sec, time_sub, fswait, output ready);
endinterface

interface dsq_res_if ();
  logic                          valid;
  logic                          ready;
  logic [dsq_pkg::PROC_ID_W-1:0] woken_id;
  logic                          woken_fswait;
  logic [dsq_pkg::STATUS_W-1:0]  status;
  logic                          last;

  modport source (output valid, woken_id, woken_fswait, status, last, input ready);
  modport sink   (input valid, woken_id, woken_fswait, status, last, output ready);
endinterface

// File: hw/rtl/deadline_sleep_queue_core.sv
`timescale 1ns / 1ps
// Top level of the deadline sleep queue: controller plus datapath behind two channels.
// Depends on dsq_pkg, dsq_if, dsq_ctrl and dsq_datapath.
//
//   Channel  Direction  Carries
//   req_i    in         kind, proc_id, time_sec, time_sub, fswait
//   res_o    out        woken_id, woken_fswait, status, last
//
// Requests are taken only while idle. An insert searches for the id, then moves each later
// entry up and writes the new one; a cancel searches, then moves each later entry down; a
// tick pops due heads, at most MAX_RESULTS, and moves the entries left behind down, or ends
// when nothing is due; one entry is read per cycle unless a further result stalls the walk.
// Reset clears the entry count and the controller; entry contents are not cleared.
// A waiting result does not block the next request, but a further result stalls the walk.

module deadline_sleep_queue_core (
  input  logic   clk_i,
  input  logic   rst_ni,
  dsq_req_if.sink   req_i,
  dsq_res_if.source res_o
);

  dsq_pkg::dsq_cmd_t  cmd;
  dsq_pkg::dsq_stat_t stat;

  // The controller sees only the request handshake and its kind; all payload
  // is latched by the datapath on the load command.
  dsq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_kind_i  (req_i.kind),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath owns the sorted entries and the result register that drives
  // the output channel directly.
  dsq_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .req_proc_id_i      (req_i.proc_id),
    .req_time_sec_i     (req_i.time_sec),
    .req_time_sub_i     (req_i.time_sub),
    .req_fswait_i       (req_i.fswait),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .res_valid_o        (res_o.valid),
    .res_ready_i        (res_o.ready),
    .res_woken_id_o     (res_o.woken_id),
    .res_woken_fswait_o (res_o.woken_fswait),
    .res_status_o       (res_o.status),
    .res_last_o         (res_o.last)
  );

endmodule

// File: hw/rtl/dsq_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the sleep queue: sequences search, shifts and results.
// Depends on dsq_pkg and the assertion macro header.
`include "deadline_sleep_queue_core_assert.svh"

module dsq_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  input  logic [dsq_pkg::KIND_W-1:0] req_kind_i,
  output logic                       req_ready_o,
  input  dsq_pkg::dsq_stat_t         stat_i,
  output dsq_pkg::dsq_cmd_t          cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_REMOVE,
    S_TICK,
    S_EMIT
  } state_e;

  state_e           state_q, state_d;
  dsq_pkg::kind_e   kind_q, kind_d;
  dsq_pkg::status_e res_status_q, res_status_d;
  logic             res_last_q, res_last_d;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d           = state_q;
    kind_d            = kind_q;
    res_status_d      = res_status_q;
    res_last_d        = res_last_q;
    cmd_o.op          = dsq_pkg::OP_NONE;
    cmd_o.rd_sel      = dsq_pkg::RD_PTR;
    cmd_o.res_status  = res_status_q;
    cmd_o.res_last    = res_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.op = dsq_pkg::OP_LOAD;
          kind_d   = dsq_pkg::kind_e'(req_kind_i);
          unique case (dsq_pkg::kind_e'(req_kind_i)) inside
            dsq_pkg::KIND_INSERT, dsq_pkg::KIND_CANCEL: state_d = S_SEARCH;
            dsq_pkg::KIND_TICK:                         state_d = S_TICK;
            default:                                    state_d = S_IDLE;
          endcase
        end
      end

      S_SEARCH: begin
        cmd_o.rd_sel = dsq_pkg::RD_PTR;
        if (!stat_i.search_done) begin
          cmd_o.op = dsq_pkg::OP_SEARCH;
        end else begin
          res_last_d = 1'b1;
          if (kind_q == dsq_pkg::KIND_INSERT) begin
            if (stat_i.found) begin
              res_status_d = dsq_pkg::ST_ALREADY;
              state_d      = S_EMIT;
            end else if (stat_i.full) begin
              res_status_d = dsq_pkg::ST_FULL;
              state_d      = S_EMIT;
            end else begin
              cmd_o.op = dsq_pkg::OP_INS_START;
              state_d  = S_SHIFT;
            end
          end else if (stat_i.found) begin
            state_d = S_REMOVE;
          end else begin
            res_status_d = dsq_pkg::ST_NOT_FOUND;
            state_d      = S_EMIT;
          end
        end
      end

      S_SHIFT: begin
        cmd_o.rd_sel = dsq_pkg::RD_PREV;
        if (stat_i.shift_more) begin
          cmd_o.op = dsq_pkg::OP_SHIFT_UP;
        end else begin
          cmd_o.op     = dsq_pkg::OP_INS_WRITE;
          res_status_d = dsq_pkg::ST_INSERTED;
          res_last_d   = 1'b1;
          state_d      = S_EMIT;
        end
      end

      S_REMOVE: begin
        cmd_o.rd_sel = dsq_pkg::RD_NEXT;
        if (stat_i.remove_more) begin
          cmd_o.op = dsq_pkg::OP_SHIFT_DOWN;
        end else begin
          cmd_o.op = dsq_pkg::OP_REMOVE_END;
          if (kind_q == dsq_pkg::KIND_TICK) begin
            state_d = S_TICK;
          end else begin
            res_status_d = dsq_pkg::ST_CANCELLED;
            res_last_d   = 1'b1;
            state_d      = S_EMIT;
          end
        end
      end

      S_TICK: begin
        cmd_o.rd_sel = dsq_pkg::RD_HEAD;
        if (stat_i.head_due && stat_i.room) begin
          if (stat_i.pend_valid) begin
            // Another entry is due, so the held one is not the final result.
            res_status_d = dsq_pkg::ST_WOKEN;
            res_last_d   = 1'b0;
            state_d      = S_EMIT;
          end else begin
            cmd_o.op = dsq_pkg::OP_POP_HEAD;
            state_d  = S_REMOVE;
          end
        end else if (stat_i.pend_valid) begin
          res_status_d = dsq_pkg::ST_WOKEN;
          res_last_d   = 1'b1;
          state_d      = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.op = dsq_pkg::OP_EMIT;
          if (res_status_q == dsq_pkg::ST_WOKEN && !res_last_q) begin
            state_d = S_TICK;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      kind_q       <= dsq_pkg::KIND_INSERT;
      res_status_q <= dsq_pkg::ST_INSERTED;
      res_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      kind_q       <= kind_d;
      res_status_q <= res_status_d;
      res_last_q   <= res_last_d;
    end
  end

  `DSQ_ASSERT_IMPLIES(a_pop_only_due, cmd_o.op == dsq_pkg::OP_POP_HEAD, stat_i.head_due && stat_i.room && !stat_i.pend_valid, "pop issued without a due head or budget")
  `DSQ_ASSERT_IMPLIES(a_insert_has_room, cmd_o.op == dsq_pkg::OP_INS_WRITE, !stat_i.full && !stat_i.found, "insert written into a full queue or for a queued process")
  `DSQ_ASSERT_IMPLIES(a_woken_from_tick, state_q == S_EMIT && res_status_q == dsq_pkg::ST_WOKEN, kind_q == dsq_pkg::KIND_TICK && stat_i.pend_valid, "woken result without a tick entry held")

endmodule

// File: hw/rtl/dsq_datapath.sv
`timescale 1ns / 1ps
// Datapath of the sleep queue: entry registers, walk pointer, compares and result register.
// Depends on dsq_pkg and the assertion macro header.
`include "deadline_sleep_queue_core_assert.svh"

module dsq_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [dsq_pkg::PROC_ID_W-1:0]   req_proc_id_i,
  input  logic [dsq_pkg::TIME_W-1:0]      req_time_sec_i,
  input  logic [dsq_pkg::TIME_W-1:0]      req_time_sub_i,
  input  logic                            req_fswait_i,
  input  dsq_pkg::dsq_cmd_t               cmd_i,
  output dsq_pkg::dsq_stat_t              stat_o,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output logic [dsq_pkg::PROC_ID_W-1:0]   res_woken_id_o,
  output logic                            res_woken_fswait_o,
  output logic [dsq_pkg::STATUS_W-1:0]    res_status_o,
  output logic                            res_last_o
);

  localparam int PidW    = dsq_pkg::PID_BITS;
  localparam int PidOutW = dsq_pkg::PROC_ID_W;
  localparam int IdxW    = dsq_pkg::IDX_W;
  localparam int CntW    = dsq_pkg::CNT_W;
  localparam int NumW    = dsq_pkg::NUM_W;

  // Entry storage, undefined until written.
  dsq_pkg::time_t sec_q [dsq_pkg::QUEUE_DEPTH];
  dsq_pkg::time_t sub_q [dsq_pkg::QUEUE_DEPTH];
  dsq_pkg::pid_t  pid_q [dsq_pkg::QUEUE_DEPTH];
  logic           fsw_q [dsq_pkg::QUEUE_DEPTH];

  // Latched request.
  dsq_pkg::pid_t  req_pid_q;
  dsq_pkg::time_t req_sec_q, req_sub_q;
  logic           req_fsw_q;

  // Walk and queue control.
  dsq_pkg::cnt_t count_q, count_d;
  dsq_pkg::cnt_t ptr_q, ptr_d;
  logic          found_q, found_d;
  dsq_pkg::num_t nwoke_q, nwoke_d;
  logic          pend_valid_q, pend_valid_d;
  dsq_pkg::pid_t pend_pid_q;
  logic          pend_fsw_q;

  // Result register.
  logic                    out_valid_q, out_valid_d;
  logic [PidOutW-1:0]      out_pid_q;
  logic                    out_fsw_q;
  dsq_pkg::status_e        out_status_q;
  logic                    out_last_q;

  dsq_pkg::cnt_t  ptr_prev, ptr_next;
  dsq_pkg::idx_t  rd_idx, wr_idx;
  dsq_pkg::time_t rd_sec, rd_sub;
  dsq_pkg::pid_t  rd_pid;
  logic           rd_fsw;
  logic           rd_later;
  logic           wr_en;
  logic           from_pend;

  assign ptr_prev = ptr_q - CntW'(1);
  assign ptr_next = ptr_q + CntW'(1);

  always_comb begin
    case (cmd_i.rd_sel)
      dsq_pkg::RD_PTR:  rd_idx = ptr_q[IdxW-1:0];
      dsq_pkg::RD_PREV: rd_idx = ptr_prev[IdxW-1:0];
      dsq_pkg::RD_NEXT: rd_idx = ptr_next[IdxW-1:0];
      default:          rd_idx = '0;
    endcase
  end

  assign rd_sec = sec_q[rd_idx];
  assign rd_sub = sub_q[rd_idx];
  assign rd_pid = pid_q[rd_idx];
  assign rd_fsw = fsw_q[rd_idx];

  // The entry read is strictly later than the request time.
  assign rd_later = {rd_sec, rd_sub} > {req_sec_q, req_sub_q};

  assign stat_o.search_done = found_q || (ptr_q >= count_q);
  assign stat_o.found       = found_q;
  assign stat_o.full        = (count_q == CntW'(dsq_pkg::QUEUE_DEPTH));
  assign stat_o.shift_more  = (ptr_q != '0) && rd_later;
  assign stat_o.remove_more = ({1'b0, ptr_q} + (CntW + 1)'(1)) < {1'b0, count_q};
  assign stat_o.head_due    = (count_q != '0) && !rd_later;
  assign stat_o.room        = (nwoke_q < NumW'(dsq_pkg::MAX_RESULTS));
  assign stat_o.pend_valid  = pend_valid_q;
  assign stat_o.out_free    = !out_valid_q || res_ready_i;

  assign wr_en  = (cmd_i.op == dsq_pkg::OP_SHIFT_UP) || (cmd_i.op == dsq_pkg::OP_SHIFT_DOWN) ||
                  (cmd_i.op == dsq_pkg::OP_INS_WRITE);
  assign wr_idx = ptr_q[IdxW-1:0];
  assign from_pend = (cmd_i.res_status == dsq_pkg::ST_WOKEN);

  always_comb begin
    count_d      = count_q;
    ptr_d        = ptr_q;
    found_d      = found_q;
    nwoke_d      = nwoke_q;
    pend_valid_d = pend_valid_q;
    out_valid_d  = out_valid_q && !res_ready_i;
    unique case (cmd_i.op)
      dsq_pkg::OP_LOAD: begin
        ptr_d        = '0;
        found_d      = 1'b0;
        nwoke_d      = '0;
        pend_valid_d = 1'b0;
      end
      dsq_pkg::OP_SEARCH: begin
        if (rd_pid == req_pid_q) begin
          found_d = 1'b1;
        end else begin
          ptr_d = ptr_next;
        end
      end
      dsq_pkg::OP_INS_START: ptr_d = count_q;
      dsq_pkg::OP_SHIFT_UP:  ptr_d = ptr_prev;
      dsq_pkg::OP_INS_WRITE: count_d = count_q + CntW'(1);
      dsq_pkg::OP_SHIFT_DOWN: ptr_d = ptr_next;
      dsq_pkg::OP_REMOVE_END: count_d = count_q - CntW'(1);
      dsq_pkg::OP_POP_HEAD: begin
        ptr_d        = '0;
        pend_valid_d = 1'b1;
        nwoke_d      = nwoke_q + NumW'(1);
      end
      dsq_pkg::OP_EMIT: begin
        out_valid_d = 1'b1;
        if (from_pend) begin
          pend_valid_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      ptr_q        <= '0;
      found_q      <= 1'b0;
      nwoke_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      ptr_q        <= ptr_d;
      found_q      <= found_d;
      nwoke_q      <= nwoke_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == dsq_pkg::OP_LOAD) begin
      req_pid_q <= PidW'(req_proc_id_i);
      req_sec_q <= req_time_sec_i;
      req_sub_q <= req_time_sub_i;
      req_fsw_q <= req_fswait_i;
    end
    if (cmd_i.op == dsq_pkg::OP_POP_HEAD) begin
      pend_pid_q <= rd_pid;
      pend_fsw_q <= rd_fsw;
    end
    if (cmd_i.op == dsq_pkg::OP_EMIT) begin
      out_pid_q    <= from_pend ? PidOutW'(pend_pid_q) : PidOutW'(req_pid_q);
      out_fsw_q    <= from_pend ? pend_fsw_q : 1'b0;
      out_status_q <= cmd_i.res_status;
      out_last_q   <= cmd_i.res_last;
    end
    if (wr_en) begin
      if (cmd_i.op == dsq_pkg::OP_INS_WRITE) begin
        sec_q[wr_idx] <= req_sec_q;
        sub_q[wr_idx] <= req_sub_q;
        pid_q[wr_idx] <= req_pid_q;
        fsw_q[wr_idx] <= req_fsw_q;
      end else begin
        sec_q[wr_idx] <= rd_sec;
        sub_q[wr_idx] <= rd_sub;
        pid_q[wr_idx] <= rd_pid;
        fsw_q[wr_idx] <= rd_fsw;
      end
    end
  end

  assign res_valid_o        = out_valid_q;
  assign res_woken_id_o     = out_pid_q;
  assign res_woken_fswait_o = out_fsw_q;
  assign res_status_o       = out_status_q;
  assign res_last_o         = out_last_q;

  `DSQ_ASSERT_NEVER(a_count_bound, count_q > CntW'(dsq_pkg::QUEUE_DEPTH), "entry count above queue depth")
  `DSQ_ASSERT_NEVER(a_ptr_bound, ptr_q > count_q, "walk pointer beyond entry count")
  `DSQ_ASSERT_IMPLIES(a_emit_into_free, cmd_i.op == dsq_pkg::OP_EMIT, !out_valid_q || res_ready_i, "result loaded over an untaken result")

endmodule

// File: tb/deadline_sleep_queue_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of deadline_sleep_queue_core: a directed table, then random traffic.
// Expected results come from the typed rows themselves or from a sorted sleeper queue in the bench.
// Depends on dsq_pkg, the dsq_req_if / dsq_res_if interfaces and the RTL of the block.
module deadline_sleep_queue_core_tb;
  import dsq_pkg::*;

  // The request kind field is two bits wide, and the fourth code is not an operation.
  // The block must drop such a request without a result and without touching its queue.
  localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 9;
  localparam int GAP_MAX       = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_REPORTS   = 10;
  localparam int PID_POOL_SIZE = 20;
  // A request that causes no result (a tick with nothing due, an ignored kind) can still
  // keep the walk busy. Insert and cancel walks search the queue and move each entry at
  // most once, so this settle time covers any of them once the result stream has gone quiet.
  localparam int SETTLE_CYCLES = 64;
  // The slowest correct run is far below this: a tick that empties a full queue walks the rest
  // of the queue for each woken entry, and there are fewer than three hundred requests in all.
  localparam int CYCLE_LIMIT   = 400_000;

  localparam time_t TIME_MAX = '1;

  typedef struct {
    logic [KIND_W-1:0]    kind;
    logic [PROC_ID_W-1:0] pid;
    time_t                sec;
    time_t                sub;
    logic                 fsw;
  } sleep_req_t;

  // One row of the directed table. Where typed is set, the expectation is written in the
  // row itself (typed_n results of status typed_st for the request's own id); otherwise
  // the row is checked against the predicted queue.
  typedef struct {
    sleep_req_t req;
    bit         typed;
    int         typed_n;
    status_e    typed_st;
  } table_row_t;

  typedef struct {
    logic [PROC_ID_W-1:0] id;
    logic                 fsw;
    status_e              st;
    logic                 last;
  } wake_result_t;

  typedef struct {
    time_t sec;
    time_t sub;
    pid_t  pid;
    logic  fsw;
  } shadow_entry_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dsq_req_if req_ch ();
  dsq_res_if res_ch ();

  deadline_sleep_queue_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .res_o  (res_ch)
  );

  // Shadow of the block: sleepers in deadline order, head first.
  shadow_entry_t sleepers[$];
  // Results still owed by the block, oldest first.
  wake_result_t  owed_results[$];
  // Results of the latest request, as the shadow queue computes them.
  wake_result_t  step_results[$];
  table_row_t    directed_rows[$];

  logic [PROC_ID_W-1:0] pid_pool[PID_POOL_SIZE];
  time_t now_sec;
  time_t now_sub;

  int err_count    = 0;
  int send_gap_max = GAP_MAX;
  int recv_gap_max = GAP_MAX;
  // Set by the stimulus to ask the result side for one long hold-off.
  int result_hold  = 0;

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  initial begin : watchdog
    #(CYCLE_LIMIT * 2 * CLK_HALF);
    $display("FAIL deadline_sleep_queue_core");
    $finish;
  end

  function automatic void report_error(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("[%0t] %s", $time, msg);
    end
  endfunction

  function automatic wake_result_t outcome(logic [PROC_ID_W-1:0] id, logic fsw, status_e st,
                                           logic last);
    wake_result_t w;
    w.id   = id;
    w.fsw  = fsw;
    w.st   = st;
    w.last = last;
    return w;
  endfunction

  // True when deadline (s, ss) lies strictly after the time (ts, tss).
  function automatic bit deadline_after(time_t s, time_t ss, time_t ts, time_t tss);
    return (s > ts) || (s == ts && ss > tss);
  endfunction

  // Apply one accepted request to the shadow queue and leave its results in step_results.
  function automatic void apply_to_shadow(sleep_req_t r);
    pid_t          p;
    int            at;
    int            pos;
    shadow_entry_t e;
    p  = r.pid[PID_BITS-1:0];
    at = -1;
    step_results.delete();
    foreach (sleepers[i]) begin
      if (at < 0 && sleepers[i].pid == p) at = i;
    end
    case (r.kind)
      KIND_INSERT: begin
        // A process that is already queued is reported as such even when the queue is full.
        if (at >= 0) begin
          step_results.push_back(outcome(p, 1'b0, ST_ALREADY, 1'b1));
        end else if (sleepers.size() >= QUEUE_DEPTH) begin
          step_results.push_back(outcome(p, 1'b0, ST_FULL, 1'b1));
        end else begin
          // The new sleeper goes behind every deadline that is equal or earlier.
          pos = sleepers.size();
          while (pos > 0 && deadline_after(sleepers[pos-1].sec, sleepers[pos-1].sub,
                                           r.sec, r.sub)) begin
            pos--;
          end
          e.sec = r.sec;
          e.sub = r.sub;
          e.pid = p;
          e.fsw = r.fsw;
          sleepers.insert(pos, e);
          step_results.push_back(outcome(p, 1'b0, ST_INSERTED, 1'b1));
        end
      end
      KIND_CANCEL: begin
        if (at < 0) begin
          step_results.push_back(outcome(p, 1'b0, ST_NOT_FOUND, 1'b1));
        end else begin
          sleepers.delete(at);
          step_results.push_back(outcome(p, 1'b0, ST_CANCELLED, 1'b1));
        end
      end
      KIND_TICK: begin
        // Pop due sleepers from the head; a tick wakes at most MAX_RESULTS of them.
        while (step_results.size() < MAX_RESULTS && sleepers.size() > 0 &&
               !deadline_after(sleepers[0].sec, sleepers[0].sub, r.sec, r.sub)) begin
          step_results.push_back(outcome(sleepers[0].pid, sleepers[0].fsw, ST_WOKEN, 1'b0));
          void'(sleepers.pop_front());
        end
        if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void add_row(logic [KIND_W-1:0] kind, logic [PROC_ID_W-1:0] pid,
                                  time_t sec, time_t sub, logic fsw,
                                  bit typed, int typed_n, status_e typed_st);
    table_row_t row;
    row.req.kind = kind;
    row.req.pid  = pid;
    row.req.sec  = sec;
    row.req.sub  = sub;
    row.req.fsw  = fsw;
    row.typed    = typed;
    row.typed_n  = typed_n;
    row.typed_st = typed_st;
    directed_rows.push_back(row);
  endfunction

  // Draws one random request. Deadlines stay close to a running clock so that ticks find
  // some sleepers due and others not; fill_heavy biases the mix toward inserts.
  function automatic sleep_req_t random_request(bit fill_heavy);
    sleep_req_t r;
    int         roll;
    int         pick;
    time_t      adv;
    roll  = $urandom_range(0, 99);
    if (fill_heavy) roll = roll % 60;
    r.fsw = 1'($urandom_range(0, 1));
    r.pid = pid_pool[$urandom_range(0, PID_POOL_SIZE - 1)];
    if ($urandom_range(0, 9) == 0) r.pid = PROC_ID_W'($urandom);
    r.sec = now_sec;
    r.sub = now_sub;
    if (roll < 50) begin
      r.kind = KIND_INSERT;
      pick   = $urandom_range(0, 99);
      if (pick < 15 && sleepers.size() > 0) begin
        // Same deadline as a queued sleeper, so arrival order decides.
        pick  = $urandom_range(0, sleepers.size() - 1);
        r.sec = sleepers[pick].sec;
        r.sub = sleepers[pick].sub;
      end else if (pick < 25) begin
        // Already overdue: due at the next tick.
        r.sec = now_sec - 1;
        r.sub = $urandom;
      end else begin
        r.sec = now_sec + $urandom_range(0, 2);
        r.sub = $urandom;
      end
    end else if (roll < 70) begin
      r.kind = KIND_CANCEL;
      if (sleepers.size() > 0 && $urandom_range(0, 3) != 0) begin
        r.pid = sleepers[$urandom_range(0, sleepers.size() - 1)].pid;
      end
    end else if (roll < 96) begin
      r.kind = KIND_TICK;
      adv    = $urandom_range(0, 32'h6000_0000);
      if (now_sub > TIME_MAX - adv) now_sec = now_sec + 1;
      now_sub = now_sub + adv;
      if ($urandom_range(0, 3) == 0) now_sec = now_sec + 1;
      r.sec = now_sec;
      r.sub = now_sub;
      // Now and then a tick at the end of time drains everything that is queued.
      if ($urandom_range(0, 24) == 0) begin
        r.sec = TIME_MAX;
        r.sub = TIME_MAX;
      end
    end else begin
      r.kind = KIND_IGNORED;
      r.sec  = $urandom;
      r.sub  = $urandom;
    end
    return r;
  endfunction

  // Offers one request after a random gap and waits for the handshake. Valid is left high
  // after acceptance so that a following request with no gap goes out back to back.
  task automatic issue_request(sleep_req_t r, bit typed, int typed_n, status_e typed_st);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.kind     <= r.kind;
    req_ch.proc_id  <= r.pid;
    req_ch.time_sec <= r.sec;
    req_ch.time_sub <= r.sub;
    req_ch.fswait   <= r.fsw;
    do @(posedge clk_i); while (!req_ch.ready);
    // The shadow queue moves on every accepted request, typed row or not.
    apply_to_shadow(r);
    if (typed) begin
      for (int i = 0; i < typed_n; i++) begin
        owed_results.push_back(outcome(r.pid, 1'b0, typed_st, 1'b1));
      end
    end else begin
      foreach (step_results[i]) owed_results.push_back(step_results[i]);
    end
  endtask

  // Stops offering requests until every owed result has arrived and the walk has settled.
  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Result side: a random stall before each result, or the long hold-off when asked.
  // Every accepted result is compared with the oldest one still owed.
  initial begin : result_sink
    int           stall;
    wake_result_t want;
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (result_hold > 0) begin
        stall       = result_hold;
        result_hold = 0;
      end else begin
        stall = $urandom_range(0, recv_gap_max);
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!res_ch.valid);
      if (owed_results.size() == 0) begin
        report_error($sformatf("unexpected result: id=%0h fsw=%0b status=%0d last=%0b",
                               res_ch.woken_id, res_ch.woken_fswait, res_ch.status,
                               res_ch.last));
      end else begin
        want = owed_results.pop_front();
        if (res_ch.woken_id !== want.id || res_ch.woken_fswait !== want.fsw ||
            res_ch.status !== want.st || res_ch.last !== want.last) begin
          report_error($sformatf({"result mismatch: expected id=%0h fsw=%0b status=%0d ",
                                  "last=%0b, got id=%0h fsw=%0b status=%0d last=%0b"},
                                 want.id, want.fsw, want.st, want.last,
                                 res_ch.woken_id, res_ch.woken_fswait, res_ch.status,
                                 res_ch.last));
        end
      end
    end
  end

  initial begin : stimulus
    rst_ni          <= 1'b0;
    req_ch.valid    <= 1'b0;
    req_ch.kind     <= KIND_INSERT;
    req_ch.proc_id  <= '0;
    req_ch.time_sec <= '0;
    req_ch.time_sub <= '0;
    req_ch.fswait   <= 1'b0;
    foreach (pid_pool[k]) pid_pool[k] = PROC_ID_W'($urandom);
    now_sec = $urandom_range(16, 32'h7fff_ffff);
    now_sub = $urandom;

    // Empty queue right after reset: nothing is due and nothing can be cancelled.
    add_row(KIND_TICK,    15'h0000, '0, '0, 1'b0, 1'b1, 0, ST_WOKEN);
    add_row(KIND_CANCEL,  15'h0000, '0, '0, 1'b0, 1'b1, 1, ST_NOT_FOUND);
    // Largest id with the latest deadline, then the same id again, then the earliest.
    add_row(KIND_INSERT,  15'h7fff, TIME_MAX, TIME_MAX, 1'b1, 1'b1, 1, ST_INSERTED);
    add_row(KIND_INSERT,  15'h7fff, 32'd5, 32'd5, 1'b0, 1'b1, 1, ST_ALREADY);
    add_row(KIND_INSERT,  15'h0000, '0, '0, 1'b0, 1'b1, 1, ST_INSERTED);
    // Equal deadlines keep arrival order; an earlier subsecond goes ahead of both.
    add_row(KIND_INSERT,  15'h0005, 32'd100, 32'd7, 1'b1, 1'b0, 0, ST_WOKEN);
    add_row(KIND_INSERT,  15'h0006, 32'd100, 32'd7, 1'b0, 1'b0, 0, ST_WOKEN);
    add_row(KIND_INSERT,  15'h2a07, 32'd100, 32'd6, 1'b1, 1'b0, 0, ST_WOKEN);
    // The unused kind with every field at its maximum must be dropped.
    add_row(KIND_IGNORED, 15'h7fff, TIME_MAX, TIME_MAX, 1'b1, 1'b1, 0, ST_WOKEN);
    // Due exactly at the deadline: wakes the zero entry and the earlier subsecond.
    add_row(KIND_TICK,    15'h7fff, 32'd100, 32'd6, 1'b0, 1'b0, 0, ST_WOKEN);
    // Cancel from the middle, then a tick at the end of time empties the queue.
    add_row(KIND_CANCEL,  15'h0006, '0, '0, 1'b0, 1'b1, 1, ST_CANCELLED);
    add_row(KIND_TICK,    15'h0000, TIME_MAX, TIME_MAX, 1'b0, 1'b0, 0, ST_WOKEN);
    // Fill the queue with a few shared deadlines, then probe it while full: a new
    // process is refused as full, a queued one is reported as already queued.
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      add_row(KIND_INSERT, PROC_ID_W'(15'h1234 + i * 37), 32'd1000 + (i % 3), i % 2,
              1'(i % 2), 1'b0, 0, ST_WOKEN);
    end
    add_row(KIND_INSERT,  15'h0777, 32'd1, 32'd1, 1'b0, 1'b1, 1, ST_FULL);
    add_row(KIND_INSERT,  15'h1234, 32'd1, 32'd1, 1'b0, 1'b1, 1, ST_ALREADY);
    // One tick wakes the whole full queue, as many results as one request can cause.
    add_row(KIND_TICK,    15'h0000, TIME_MAX, TIME_MAX, 1'b0, 1'b0, 0, ST_WOKEN);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      issue_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].typed_n,
                    directed_rows[k].typed_st);
    end
    wait_for_results();

    // Random traffic with idling on both sides.
    repeat (60) issue_request(random_request(1'b0), 1'b0, 0, ST_WOKEN);

    // The result side holds off for a long stretch while requests, mostly inserts, arrive back
    // to back, so the output slot fills and the block has to stall its request side.
    send_gap_max = 0;
    result_hold  = HOLD_CYCLES;
    repeat (30) issue_request(random_request(1'b1), 1'b0, 0, ST_WOKEN);
    send_gap_max = GAP_MAX;
    wait_for_results();

    // A stretch with no idling at all.
    send_gap_max = 0;
    recv_gap_max = 0;
    repeat (60) issue_request(random_request(1'b0), 1'b0, 0, ST_WOKEN);

    send_gap_max = GAP_MAX;
    recv_gap_max = GAP_MAX;
    repeat (50) issue_request(random_request(1'b0), 1'b0, 0, ST_WOKEN);
    wait_for_results();

    if (err_count == 0 && owed_results.size() == 0) begin
      $display("PASS deadline_sleep_queue_core");
    end else begin
      $display("FAIL deadline_sleep_queue_core");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/dsq_pkg.sv
hw/rtl/dsq_if.sv
hw/rtl/dsq_ctrl.sv
hw/rtl/dsq_datapath.sv
hw/rtl/deadline_sleep_queue_core.sv
tb/deadline_sleep_queue_core_tb.sv
